// File: rtl/core/tcgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_pkg
// Types and constants of the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  // font memory and glyph limits
  localparam int unsigned FontBytes      = 16384;
  localparam int unsigned FontAw         = $clog2(FontBytes);
  localparam int unsigned MaxGlyphHeight = 32;
  localparam int unsigned MaxGlyphWidth  = 16;

  // console limits
  localparam logic [9:0] RowMax      = 10'd1023;
  localparam logic [7:0] CharNewline = 8'd10;

  // configuration port
  localparam int unsigned CfgAw = 6;
  localparam int unsigned CfgDw = 64;

  localparam logic [2:0] RegFrameBase   = 3'd0;
  localparam logic [2:0] RegLinePitch   = 3'd1;
  localparam logic [2:0] RegGlyphWidth  = 3'd2;
  localparam logic [2:0] RegGlyphHeight = 3'd3;
  localparam logic [2:0] RegGlyphBytes  = 3'd4;
  localparam logic [2:0] RegTextColumns = 3'd5;

  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdPrint = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [13:0] font_addr;
    logic [7:0]  font_byte;
    logic [7:0]  character;
  } in_item_t;

  typedef struct packed {
    logic [47:0] row_address;
    logic [15:0] pixel_mask;
    logic        last_row;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/core/text_console_glyph_renderer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// Bitmap font text console: loads font bytes, prints characters as one
// framebuffer row request per glyph line and keeps the text cursor.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+-------------
//  in       | in        | in_valid_i / in_stall_o        | in_item_i
//  out      | out       | out_valid_o / out_stall_i      | out_item_o
//  config   | in        | psel/penable/pwrite/pready     | paddr, pwdata
//
//  font load and newline do not hold the input; a printed glyph steps through
//  the request, four shared multiplier passes and one address add, then two
//  font memory reads and one emit per glyph row (clamped glyph height). a
//  stalled output holds the emit, and the last row may wait in the output
//  register while the next request is taken.
//  font memory has no reset; cursor and registers reset.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer
  import tcgr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_item_t         in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_item_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [CfgAw-1:0] paddr,
  input  wire logic [CfgDw-1:0] pwdata,
  output logic      [CfgDw-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MROW,
    S_MPITCH,
    S_MCOL,
    S_MCHR,
    S_BASE,
    S_RD0,
    S_RD1,
    S_EMIT
  } state_e;

  // configuration registers
  logic [47:0] frame_base_q;
  logic [13:0] line_pitch_q;
  logic [4:0]  glyph_width_q;
  logic [5:0]  glyph_height_q;
  logic [6:0]  glyph_bytes_q;
  logic [9:0]  text_columns_q;

  logic [2:0] reg_idx;
  logic       cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q   <= 48'd0;
      line_pitch_q   <= 14'd1920;
      glyph_width_q  <= 5'd8;
      glyph_height_q <= 6'd16;
      glyph_bytes_q  <= 7'd16;
      text_columns_q <= 10'd240;
    end else if (cfg_we) begin
      unique case (reg_idx)
        RegFrameBase:   frame_base_q   <= pwdata[47:0];
        RegLinePitch:   line_pitch_q   <= pwdata[13:0];
        RegGlyphWidth:  glyph_width_q  <= pwdata[4:0];
        RegGlyphHeight: glyph_height_q <= pwdata[5:0];
        RegGlyphBytes:  glyph_bytes_q  <= pwdata[6:0];
        RegTextColumns: text_columns_q <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegFrameBase:   prdata = CfgDw'(frame_base_q);
      RegLinePitch:   prdata = CfgDw'(line_pitch_q);
      RegGlyphWidth:  prdata = CfgDw'(glyph_width_q);
      RegGlyphHeight: prdata = CfgDw'(glyph_height_q);
      RegGlyphBytes:  prdata = CfgDw'(glyph_bytes_q);
      RegTextColumns: prdata = CfgDw'(text_columns_q);
      default:        prdata = '0;
    endcase
  end

  // clamped glyph geometry
  logic [4:0]  gw;
  logic [5:0]  gh;
  logic [1:0]  bpr;
  logic [16:0] width_mask;

  assign gw  = (glyph_width_q > 5'(MaxGlyphWidth)) ? 5'(MaxGlyphWidth) : glyph_width_q;
  assign gh  = (glyph_height_q > 6'(MaxGlyphHeight)) ? 6'(MaxGlyphHeight) : glyph_height_q;
  assign bpr = 2'((6'(gw) + 6'd7) >> 3);
  assign width_mask = (17'd1 << gw) - 17'd1;

  state_e      state_q;
  logic [9:0]  cursor_col_q;
  logic [9:0]  cursor_row_q;
  logic [7:0]  char_q;
  logic [14:0] rowh_q;
  logic [28:0] lin_q;
  logic [14:0] colw_q;
  logic [FontAw-1:0] gptr_q;
  logic [47:0] addr_q;
  logic [5:0]  r_q;
  logic [7:0]  b0_q;
  logic        out_valid_q;
  out_item_t   out_item_q;

  // shared multiplier
  logic [14:0] mul_a;
  logic [13:0] mul_b;
  logic [28:0] mul_p;

  always_comb begin
    unique case (state_q)
      S_MROW: begin
        mul_a = 15'(cursor_row_q);
        mul_b = 14'(gh);
      end
      S_MPITCH: begin
        mul_a = rowh_q;
        mul_b = line_pitch_q;
      end
      S_MCOL: begin
        mul_a = 15'(cursor_col_q);
        mul_b = 14'(gw);
      end
      S_MCHR: begin
        mul_a = 15'(char_q);
        mul_b = 14'(glyph_bytes_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 29'(mul_a) * 29'(mul_b);

  // handshakes
  logic in_acc;
  logic out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // cursor stepping
  logic [10:0] col_inc;
  logic        col_wrap;
  logic [9:0]  row_inc;

  assign col_inc  = 11'(cursor_col_q) + 11'd1;
  assign col_wrap = (col_inc >= 11'(text_columns_q));
  assign row_inc  = (cursor_row_q == RowMax) ? cursor_row_q : cursor_row_q + 10'd1;

  // font memory: a write port for loads and a read port for glyph fetches
  logic [7:0]        font_mem [FontBytes];
  logic [7:0]        font_rd_q;
  logic              font_we;
  logic              font_re;
  logic [FontAw-1:0] font_raddr;

  assign font_we    = in_acc && (in_item_i.cmd == CmdLoad);
  assign font_re    = (state_q == S_RD0) || (state_q == S_RD1);
  assign font_raddr = (state_q == S_RD1) ? gptr_q + FontAw'(1) : gptr_q;

  always_ff @(posedge clk_i) begin
    if (font_we) begin
      font_mem[FontAw'(in_item_i.font_addr)] <= in_item_i.font_byte;
    end
    if (font_re) begin
      font_rd_q <= font_mem[font_raddr];
    end
  end

  // msb-first bitmap bytes to lsb-first pixel mask
  logic [15:0] row_bits;
  logic        is_last;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      row_bits[i]     = b0_q[7-i];
      row_bits[8 + i] = font_rd_q[7-i];
    end
  end

  assign is_last = (r_q + 6'd1 == gh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // an emit cycle refills the output register itself
      if (out_valid_q && !out_stall_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && (in_item_i.cmd == CmdPrint)) begin
            if (in_item_i.character == CharNewline) begin
              cursor_col_q <= '0;
              cursor_row_q <= row_inc;
            end else begin
              char_q  <= in_item_i.character;
              state_q <= S_MROW;
            end
          end
        end
        S_MROW: begin
          rowh_q  <= mul_p[14:0];
          state_q <= S_MPITCH;
        end
        S_MPITCH: begin
          lin_q   <= mul_p;
          state_q <= S_MCOL;
        end
        S_MCOL: begin
          colw_q  <= mul_p[14:0];
          state_q <= S_MCHR;
        end
        S_MCHR: begin
          gptr_q  <= mul_p[FontAw-1:0];
          state_q <= S_BASE;
        end
        S_BASE: begin
          addr_q <= frame_base_q + 48'({30'(lin_q) + 30'(colw_q), 2'b00});
          r_q    <= '0;
          if (gh == 6'd0) begin
            // empty glyph still moves the cursor
            if (col_wrap) begin
              cursor_col_q <= '0;
              cursor_row_q <= row_inc;
            end else begin
              cursor_col_q <= col_inc[9:0];
            end
            state_q <= S_IDLE;
          end else begin
            state_q <= S_RD0;
          end
        end
        S_RD0: begin
          state_q <= S_RD1;
        end
        S_RD1: begin
          b0_q    <= font_rd_q;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q            <= 1'b1;
            out_item_q.row_address <= addr_q;
            out_item_q.pixel_mask  <= row_bits & width_mask[15:0];
            out_item_q.last_row    <= is_last;
            addr_q <= addr_q + 48'({line_pitch_q, 2'b00});
            gptr_q <= gptr_q + FontAw'(bpr);
            r_q    <= r_q + 6'd1;
            if (is_last) begin
              if (col_wrap) begin
                cursor_col_q <= '0;
                cursor_row_q <= row_inc;
              end else begin
                cursor_col_q <= col_inc[9:0];
              end
              state_q <= S_IDLE;
            end else begin
              state_q <= S_RD0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_item_i.cmd == CmdLoad) |=> !in_stall_o)
    else $error("font load request held the input");

  a_glyph_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_item_i.cmd == CmdPrint) && (in_item_i.character != CharNewline)
    |=> in_stall_o)
    else $error("glyph request did not start the sequencer");

  a_row_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_row_q >= $past(cursor_row_q))
    else $error("cursor row moved backwards");

  a_rows_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD0) |-> (gh != 6'd0) && (r_q < gh))
    else $error("row fetch outside glyph height");
`endif

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text console glyph renderer: drives font loads,
// prints and newlines under random idling and back pressure, predicts every
// glyph row and cursor move, and compares each row field by field.
// ----------------------------------------------------------------------------
module tb;
  import tcgr_pkg::*;

  localparam int unsigned CycleLimit  = 100_000;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned MaxReports  = 10;

  class glyph_scoreboard;
    logic [47:0] frame_base;
    logic [13:0] line_pitch;
    logic [4:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [6:0]  glyph_bytes;
    logic [9:0]  text_columns;
    int unsigned cursor_col;
    int unsigned cursor_row;
    logic [7:0]  font_mem [FontBytes];
    bit          font_known [FontBytes];
    out_item_t   expected_rows [$];
    int unsigned mismatches;
    int unsigned rows_checked;
    int unsigned glyphs;
    int unsigned newlines;
    int unsigned loads;

    function new();
      frame_base   = '0;
      line_pitch   = 14'd1920;
      glyph_width  = 5'd8;
      glyph_height = 6'd16;
      glyph_bytes  = 7'd16;
      text_columns = 10'd240;
    endfunction

    function void flag(string what, logic [63:0] exp_val, logic [63:0] act_val);
      mismatches++;
      if (mismatches <= MaxReports)
        $display("[%0t] %s: expected %h, got %h", $time, what, exp_val, act_val);
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
        RegFrameBase:   frame_base   = value[47:0];
        RegLinePitch:   line_pitch   = value[13:0];
        RegGlyphWidth:  glyph_width  = value[4:0];
        RegGlyphHeight: glyph_height = value[5:0];
        RegGlyphBytes:  glyph_bytes  = value[6:0];
        RegTextColumns: text_columns = value[9:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] reg_value(logic [2:0] idx);
      case (idx)
        RegFrameBase:   return 64'(frame_base);
        RegLinePitch:   return 64'(line_pitch);
        RegGlyphWidth:  return 64'(glyph_width);
        RegGlyphHeight: return 64'(glyph_height);
        RegGlyphBytes:  return 64'(glyph_bytes);
        RegTextColumns: return 64'(text_columns);
        default:        return '0;
      endcase
    endfunction

    function int unsigned glyph_w();
      return (glyph_width > MaxGlyphWidth) ? MaxGlyphWidth : int'(glyph_width);
    endfunction

    function int unsigned glyph_h();
      return (glyph_height > MaxGlyphHeight) ? MaxGlyphHeight : int'(glyph_height);
    endfunction

    function int unsigned row_bytes();
      return (glyph_w() + 7) / 8;
    endfunction

    function int unsigned fetch_addr(int unsigned chr, int unsigned r, int unsigned k);
      return (chr * glyph_bytes + r * row_bytes() + k) % FontBytes;
    endfunction

    function void next_line();
      cursor_col = 0;
      if (cursor_row < RowMax) cursor_row++;
    endfunction

    function void render_glyph(logic [7:0] chr);
      int unsigned w;
      int unsigned h;
      logic [63:0] pix;
      logic [63:0] addr_sum;
      logic [7:0]  font_byte;
      out_item_t   row;
      w = glyph_w();
      h = glyph_h();
      for (int unsigned r = 0; r < h; r++) begin
        pix = 64'(line_pitch) * (64'(cursor_row) * h + r) + 64'(cursor_col) * w;
        addr_sum = 64'(frame_base) + (pix << 2);
        row.row_address = addr_sum[47:0];
        row.pixel_mask  = '0;
        // glyph rows are stored msb first
        for (int unsigned x = 0; x < w; x++) begin
          font_byte = font_mem[fetch_addr(chr, r, x / 8)];
          if (font_byte[7 - (x % 8)]) row.pixel_mask[x] = 1'b1;
        end
        row.last_row = (r + 1 == h);
        expected_rows.push_back(row);
      end
      glyphs++;
      cursor_col++;
      if (cursor_col >= text_columns) next_line();
    endfunction

    function void note_request(in_item_t item);
      case (item.cmd)
        CmdLoad: begin
          font_mem[item.font_addr]   = item.font_byte;
          font_known[item.font_addr] = 1'b1;
          loads++;
        end
        CmdPrint: begin
          if (item.character == CharNewline) begin
            next_line();
            newlines++;
          end else begin
            render_glyph(item.character);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_row(out_item_t got);
      out_item_t want;
      if (expected_rows.size() == 0) begin
        flag("unexpected glyph row", '0, 64'(got));
        return;
      end
      want = expected_rows.pop_front();
      rows_checked++;
      if (got.row_address !== want.row_address)
        flag("row_address", 64'(want.row_address), 64'(got.row_address));
      if (got.pixel_mask !== want.pixel_mask)
        flag("pixel_mask", 64'(want.pixel_mask), 64'(got.pixel_mask));
      if (got.last_row !== want.last_row)
        flag("last_row", 64'(want.last_row), 64'(got.last_row));
    endfunction

    function void finish_check();
      while (expected_rows.size() != 0)
        flag("glyph row never emitted", 64'(expected_rows.pop_front()), '0);
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  in_item_t         in_item_i   = '0;
  logic             out_stall_i = 1'b0;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [CfgAw-1:0] paddr       = '0;
  logic [CfgDw-1:0] pwdata      = '0;
  logic             in_stall_o;
  logic             out_valid_o;
  out_item_t        out_item_o;
  logic [CfgDw-1:0] prdata;
  logic             pready;

  glyph_scoreboard sb;
  int unsigned     cycle_count = 0;
  int unsigned     settings    = 0;
  bit              tx_quiet    = 1'b0;
  bit              rx_quiet    = 1'b0;
  bit              hold_req    = 1'b0;

  text_console_glyph_renderer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_row(out_item_o);
  end

  // output side: random stall before each row, one long hold on demand
  initial begin : receiver
    int unsigned n;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        n = rx_quiet ? 0 : $urandom_range(0, 13);
        if (n != 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
    end
  end

  function automatic int unsigned draw_gap();
    return tx_quiet ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  function automatic logic [7:0] rand_glyph_code();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CharNewline) c = c ^ 8'h01;
    return c;
  endfunction

  function automatic in_item_t load_item(logic [13:0] addr, logic [7:0] data);
    in_item_t it;
    it.cmd       = CmdLoad;
    it.font_addr = addr;
    it.font_byte = data;
    it.character = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t print_item(logic [7:0] chr);
    in_item_t it;
    it.cmd       = CmdPrint;
    it.font_addr = 14'($urandom_range(0, 16383));
    it.font_byte = 8'($urandom_range(0, 255));
    it.character = chr;
    return it;
  endfunction

  // drives the request and returns once the block has taken it
  task automatic send(input in_item_t item);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(item);
  endtask

  // fill in any glyph bytes not yet written, then print
  task automatic print_glyph(input logic [7:0] chr);
    int unsigned a;
    int unsigned nb;
    // the block may fetch two bytes per row even for narrow glyphs
    nb = (sb.row_bytes() == 0) ? 0 : 2;
    for (int unsigned r = 0; r < sb.glyph_h(); r++) begin
      for (int unsigned k = 0; k < nb; k++) begin
        a = sb.fetch_addr(chr, r, k);
        if (!sb.font_known[a]) send(load_item(a[13:0], 8'($urandom_range(0, 255))));
      end
    end
    send(print_item(chr));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_rows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [63:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== sb.reg_value(idx)) sb.flag("register readback", sb.reg_value(idx), got);
    @(posedge clk_i);
  endtask

  task automatic check_all_regs();
    check_reg(RegFrameBase);
    check_reg(RegLinePitch);
    check_reg(RegGlyphWidth);
    check_reg(RegGlyphHeight);
    check_reg(RegGlyphBytes);
    check_reg(RegTextColumns);
  endtask

  task automatic set_config(input logic [47:0] base, input int unsigned pitch,
                            input int unsigned w, input int unsigned h,
                            input int unsigned gb, input int unsigned cols);
    apb_write(RegFrameBase, 64'(base));
    apb_write(RegLinePitch, 64'(pitch));
    apb_write(RegGlyphWidth, 64'(w));
    apb_write(RegGlyphHeight, 64'(h));
    apb_write(RegGlyphBytes, 64'(gb));
    apb_write(RegTextColumns, 64'(cols));
    check_all_regs();
    settings++;
  endtask

  // mostly prints from a small character set, plus newlines and stray loads
  task automatic run_mix(input int unsigned n);
    logic [7:0]  pool [3];
    int unsigned pick;
    foreach (pool[i]) pool[i] = rand_glyph_code();
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) tx_quiet = !tx_quiet;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        print_glyph(pool[$urandom_range(0, 2)]);
      end else if (pick < 68) begin
        print_glyph(rand_glyph_code());
      end else if (pick < 82) begin
        send(print_item(CharNewline));
      end else begin
        send(load_item(14'($urandom_range(0, 16383)), 8'($urandom_range(0, 255))));
      end
    end
    tx_quiet = 1'b0;
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_all_regs();

    // directed: address wrap near the top, solid and empty glyphs, column wrap
    set_config(48'hFFFF_FFFF_FF00, 8192, 16, 2, 4, 3);
    send(load_item(14'd0, 8'h00));
    send(load_item(14'd1, 8'h00));
    send(load_item(14'd2, 8'h00));
    send(load_item(14'd3, 8'h00));
    send(load_item(14'd1020, 8'hFF));
    send(load_item(14'd1021, 8'hFF));
    send(load_item(14'd1022, 8'hFF));
    send(load_item(14'd1023, 8'hFF));
    send(load_item(14'd340, 8'hA5));
    send(load_item(14'd341, 8'h5A));
    send(load_item(14'd342, 8'h0F));
    send(load_item(14'd343, 8'hF0));
    send(load_item(14'd680, 8'h80));
    send(load_item(14'd681, 8'h01));
    send(load_item(14'd682, 8'h01));
    send(load_item(14'd683, 8'h80));
    send(print_item(8'd0));
    send(print_item(8'd255));
    send(print_item(8'h55));
    send(print_item(CharNewline));
    send(print_item(8'hAA));
    send(print_item(CharNewline));
    send(print_item(8'd255));
    wait_idle();

    set_config(rand48(), 1920, 8, 3, 3, 4);
    run_mix(10);
    wait_idle();

    // zero width gives empty masks, zero columns wraps every character
    set_config(48'h0, 1, 0, 5, 1, 0);
    run_mix(6);
    wait_idle();

    // zero height: nothing emitted, cursor still moves
    set_config(rand48(), 77, 9, 0, 64, 7);
    run_mix(6);
    wait_idle();

    // tall glyph setting clamps to the height limit, large address terms
    set_config(48'hFFFF_FFFF_FFFF, 16383, 0, 63, 127, 1023);
    send(print_item(rand_glyph_code()));
    // long output hold while prints keep coming back to back
    hold_req = 1'b1;
    tx_quiet = 1'b1;
    repeat (6) send(print_item(rand_glyph_code()));
    tx_quiet = 1'b0;
    wait_idle();

    // wide glyph setting clamps, font addresses wrap past the top of memory
    set_config(48'hFFFF_FFFF_FFFF, 16383, 31, 2, 127, 1023);
    print_glyph(8'hF7);
    print_glyph(rand_glyph_code());
    run_mix(6);
    wait_idle();

    set_config(48'h0, 1, 1, 1, 1, 1);
    run_mix(6);
    wait_idle();

    repeat (2) begin
      set_config(rand48(), $urandom_range(1, 16383), $urandom_range(0, 31),
                 $urandom_range(0, 3), $urandom_range(0, 127), $urandom_range(0, 1023));
      run_mix(4);
      wait_idle();
    end

    sb.finish_check();
    $display("checked %0d glyph rows from %0d glyphs, %0d newlines, %0d font loads",
             sb.rows_checked, sb.glyphs, sb.newlines, sb.loads);
    $display("%0d register settings incl. clamps, wraps and a long hold; %0d mismatches",
             settings, sb.mismatches);
    if (sb.mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial sb = new();

endmodule

// File: files.f
rtl/core/tcgr_pkg.sv
rtl/core/text_console_glyph_renderer.sv
bench/tb.sv
